@@ design/sitda_pkg.sv @@
`default_nettype none
package sitda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH_DEF  = 2;
  // magnitude bits taken into the BCD converter per cycle, unless its final step is held
  localparam int BITS_PER_STEP   = 4;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  // decimal digits needed for a magnitude of up to 2^(width-1)
  function automatic int num_digits(input int width);
    return ((width - 1) * 30103) / 100000 + 1;
  endfunction

endpackage
`default_nettype wire

@@ design/sitda_fifo.sv @@
`default_nettype none
module sitda_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = sitda_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ design/sitda_front.sv @@
`default_nettype none
module sitda_front #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          in_push,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [VALUE_WIDTH:0]               q_wdata
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;

  assign raw = VALUE_WIDTH'(unsigned'(in_value));
  assign neg = raw[VALUE_WIDTH-1];
  // unsigned magnitude, so the most negative value comes out as 2^(W-1)
  assign mag = neg ? (~raw + 1'b1) : raw;

  assign q_push  = in_push && !q_full;
  assign q_wdata = {neg, mag};

endmodule
`default_nettype wire

@@ design/sitda_conv.sv @@
`default_nettype none
module sitda_conv #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire logic [VALUE_WIDTH:0] q_rdata,
  output logic                    q_pop,
  output logic                    res_valid,
  output logic                    res_neg,
  output logic [sitda_pkg::num_digits(VALUE_WIDTH)*4-1:0] res_bcd,
  input  wire logic               res_take
);

  localparam int ND  = sitda_pkg::num_digits(VALUE_WIDTH);
  localparam int BW  = ND * 4;
  localparam int BPS = sitda_pkg::BITS_PER_STEP;
  localparam int CYC = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int MW  = CYC * BPS;
  localparam int CW  = (CYC > 1) ? $clog2(CYC) : 1;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] shift_r, shift_nxt;
  logic [BW-1:0] bcd_r, bcd_nxt;
  logic          neg_r, neg_nxt;
  logic          res_valid_r, res_valid_nxt;
  logic          res_neg_r, res_neg_nxt;
  logic [BW-1:0] res_bcd_r, res_bcd_nxt;

  logic          last_step, step_en, finish, start;
  logic [BW-1:0] bcd_step;

  // shift-and-add-3, BPS magnitude bits per cycle unless the final step is held
  always_comb begin
    logic [BW-1:0] b;
    b = bcd_r;
    for (int j = 0; j < BPS; j++) begin
      for (int d = 0; d < ND; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BW-2:0], shift_r[MW-1-j]};
    end
    bcd_step = b;
  end

  assign last_step = (cnt_r == CW'(CYC - 1));
  // hold the final step while the result slot is still occupied
  assign step_en   = busy_r && !(last_step && res_valid_r && !res_take);
  assign finish    = step_en && last_step;
  assign start     = (!busy_r || finish) && !q_empty;
  assign q_pop     = start;

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    res_valid_nxt = res_valid_r && !res_take;
    res_neg_nxt   = res_neg_r;
    res_bcd_nxt   = res_bcd_r;
    if (step_en) begin
      cnt_nxt   = cnt_r + 1'b1;
      shift_nxt = shift_r << BPS;
      bcd_nxt   = bcd_step;
    end
    if (finish) begin
      busy_nxt      = 1'b0;
      res_valid_nxt = 1'b1;
      res_neg_nxt   = neg_r;
      res_bcd_nxt   = bcd_step;
    end
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = MW'(q_rdata[VALUE_WIDTH-1:0]);
      bcd_nxt   = '0;
      neg_nxt   = q_rdata[VALUE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    bcd_r     <= bcd_nxt;
    neg_r     <= neg_nxt;
    res_neg_r <= res_neg_nxt;
    res_bcd_r <= res_bcd_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_neg   = res_neg_r;
  assign res_bcd   = res_bcd_r;

endmodule
`default_nettype wire

@@ design/sitda_emit.sv @@
`default_nettype none
module sitda_emit #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  res_valid,
  input  wire logic  res_neg,
  input  wire logic [sitda_pkg::num_digits(VALUE_WIDTH)*4-1:0] res_bcd,
  output logic       res_take,
  output logic       out_empty,
  input  wire logic  out_pop,
  output logic [5:0] out_char_code,
  output logic       out_last_char
);

  localparam int ND = sitda_pkg::num_digits(VALUE_WIDTH);
  localparam int BW = ND * 4;
  localparam int IW = (ND > 1) ? $clog2(ND) : 1;

  logic          busy_r, busy_nxt;
  logic          sign_r, sign_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] digits_r, digits_nxt;

  logic          xfer, final_char, load;
  logic [IW-1:0] top;
  logic [3:0]    cur_digit;

  // most significant nonzero digit; zero prints one digit
  always_comb begin
    top = '0;
    for (int i = 0; i < ND; i++) begin
      if (res_bcd[i*4 +: 4] != 4'd0) begin
        top = IW'(i);
      end
    end
  end

  assign xfer       = out_pop && busy_r;
  assign final_char = !sign_r && (idx_r == '0);
  assign load       = res_valid && (!busy_r || (xfer && final_char));
  assign res_take   = load;

  always_comb begin
    busy_nxt   = busy_r;
    sign_nxt   = sign_r;
    idx_nxt    = idx_r;
    digits_nxt = digits_r;
    if (xfer) begin
      if (sign_r) begin
        sign_nxt = 1'b0;
      end else if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
    if (load) begin
      busy_nxt   = 1'b1;
      sign_nxt   = res_neg;
      idx_nxt    = top;
      digits_nxt = res_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      sign_r <= sign_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
  end

  assign cur_digit     = digits_r[idx_r*4 +: 4];
  assign out_empty     = !busy_r;
  assign out_char_code = sign_r ? sitda_pkg::CHAR_MINUS
                                : sitda_pkg::CHAR_ZERO + {2'b00, cur_digit};
  assign out_last_char = final_char;

endmodule
`default_nettype wire

@@ design/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII text.
// Input queue: drive in_value with in_push; a transfer happens on a clock edge
// with in_push high and in_full low. Each value yields its decimal text on the
// output queue, one character per transfer, most significant first: an
// optional '-', then the digits without leading zeros (zero gives "0").
// out_last_char marks the final character. A character is valid while
// out_empty is low and is taken on an edge with out_pop high.
// Throughput: the BCD converter and the output side run concurrently; the
// output side gives one character per cycle while out_pop is held high (up
// to 11 characters at 32 bits), and the converter can take the next value
// while the previous one is still being emitted.
// An input queue of FIFO_DEPTH entries (two by default) and a result slot between converter and output let
// input keep flowing while the receiver stalls; once they fill, in_full rises.
// Synchronous reset empties every stage; nothing persists between values.
`default_nettype none
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF,
  parameter int FIFO_DEPTH  = sitda_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                               in_full,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [5:0]                         out_char_code,
  output logic                               out_last_char
);

  localparam int BW = sitda_pkg::num_digits(VALUE_WIDTH) * 4;

  logic                 q_push, q_pop, q_full, q_empty;
  logic [VALUE_WIDTH:0] q_wdata, q_rdata;
  logic                 res_valid, res_neg, res_take;
  logic [BW-1:0]        res_bcd;

  assign in_full = q_full;

  sitda_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_push (in_push),
    .in_value(in_value),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  sitda_fifo #(.WIDTH(VALUE_WIDTH + 1), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  sitda_conv #(.VALUE_WIDTH(VALUE_WIDTH)) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .res_valid(res_valid),
    .res_neg  (res_neg),
    .res_bcd  (res_bcd),
    .res_take (res_take)
  );

  sitda_emit #(.VALUE_WIDTH(VALUE_WIDTH)) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_neg      (res_neg),
    .res_bcd      (res_bcd),
    .res_take     (res_take),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

endmodule
`default_nettype wire
